// ===== rtl/tmrc_pkg.sv =====
package tmrc_pkg;

  localparam int unsigned TileRowW = 5;
  localparam int unsigned TileColW = 6;
  localparam int unsigned TileIdW  = 16;
  localparam int unsigned CoordW   = 13;
  localparam int unsigned SizeW    = 12;

  localparam int unsigned SumW     = CoordW + 1;
  localparam int unsigned DivInW   = 13;
  localparam int unsigned DivMulW  = DivInW + 1;
  localparam int unsigned DivProdW = DivInW + DivMulW;

  localparam int unsigned MaxCols  = 64;
  localparam int unsigned MaxRowW  = 8;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic                 empty;
    logic                 solid;
    logic [MaxRowW-1:0]   row_lo;
    logic [MaxRowW-1:0]   row_hi;
    logic [MaxCols-1:0]   mask;
  } cmd_t;

endpackage

// ===== rtl/tmrc_ram.sv =====
module tmrc_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tmrc_front.sv =====
module tmrc_front import tmrc_pkg::*; #(
  parameter int unsigned TILE_PIXELS = 32,
  parameter int unsigned MAP_ROWS    = 32,
  parameter int unsigned MAP_COLS    = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     mode_i,
  input  logic [TileRowW-1:0]      tile_row_i,
  input  logic [TileColW-1:0]      tile_col_i,
  input  logic [TileIdW-1:0]       tile_id_i,
  input  logic signed [CoordW-1:0] rect_x_i,
  input  logic signed [CoordW-1:0] rect_y_i,
  input  logic [SizeW-1:0]         rect_w_i,
  input  logic [SizeW-1:0]         rect_h_i,
  input  logic                     full_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  localparam int unsigned DivL     = $clog2(TILE_PIXELS);
  localparam int unsigned DivShift = DivInW + DivL;
  localparam int unsigned DivMul   = ((1 << DivShift) + TILE_PIXELS - 1) / TILE_PIXELS;
  localparam logic signed [SumW-1:0] NegTile = -$signed(SumW'(TILE_PIXELS));
  localparam logic [DivInW-1:0] ColLast = DivInW'(MAP_COLS - 1);
  localparam logic [DivInW-1:0] RowLast = DivInW'(MAP_ROWS - 1);
  localparam logic [TileColW:0] ColCount = (TileColW + 1)'(MAP_COLS);
  localparam logic [MaxRowW:0]  RowCount = (MaxRowW + 1)'(MAP_ROWS);

  function automatic logic [DivInW-1:0] div_tile(input logic [DivInW-1:0] n);
    logic [DivProdW-1:0] p;
    p = DivProdW'(n) * DivProdW'(DivMul);
    return DivInW'(p >> DivShift);
  endfunction

  logic accept;
  logic a_adv, b_adv, drop_c;

  logic                     a_valid_q;
  mode_e                    a_mode_q;
  logic [TileRowW-1:0]      a_row_q;
  logic [TileColW-1:0]      a_col_q;
  logic                     a_solid_q;
  logic signed [CoordW-1:0] a_x_q, a_y_q;
  logic signed [SumW-1:0]   a_sx_q, a_sy_q;
  logic signed [SumW-1:0]   sx_c, sy_c;

  logic                b_valid_q;
  mode_e               b_mode_q;
  logic [TileRowW-1:0] b_row_q;
  logic [TileColW-1:0] b_col_q;
  logic                b_solid_q;
  logic                b_xneg_q, b_yneg_q, b_sxneg_q, b_syneg_q, b_sxfar_q, b_syfar_q;
  logic [DivInW-1:0]   b_ql_q, b_qr_q, b_qt_q, b_qb_q;

  logic [DivInW-1:0]  left_c, right_c, top_c, bot_c;
  logic               hempty_c, vempty_c, empty_c;
  logic [MaxCols-1:0] qmask_c, wmask_c;

  assign a_adv  = a_valid_q && (!b_valid_q || b_adv);
  assign busy_o = a_valid_q && !a_adv;
  assign accept = start_i && !busy_o;

  assign sx_c = $signed({rect_x_i[CoordW-1], rect_x_i}) + $signed({2'b00, rect_w_i});
  assign sy_c = $signed({rect_y_i[CoordW-1], rect_y_i}) + $signed({2'b00, rect_h_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_mode_q  <= mode_e'(mode_i);
      a_row_q   <= tile_row_i;
      a_col_q   <= tile_col_i;
      a_solid_q <= (tile_id_i != '0);
      a_x_q     <= rect_x_i;
      a_y_q     <= rect_y_i;
      a_sx_q    <= sx_c;
      a_sy_q    <= sy_c;
    end
    if (a_adv) begin
      b_mode_q  <= a_mode_q;
      b_row_q   <= a_row_q;
      b_col_q   <= a_col_q;
      b_solid_q <= a_solid_q;
      b_xneg_q  <= a_x_q[CoordW-1];
      b_yneg_q  <= a_y_q[CoordW-1];
      b_sxneg_q <= a_sx_q[SumW-1];
      b_syneg_q <= a_sy_q[SumW-1];
      b_sxfar_q <= (a_sx_q <= NegTile);
      b_syfar_q <= (a_sy_q <= NegTile);
      b_ql_q    <= div_tile(a_x_q[CoordW-1] ? '0 : DivInW'(a_x_q));
      b_qt_q    <= div_tile(a_y_q[CoordW-1] ? '0 : DivInW'(a_y_q));
      b_qr_q    <= div_tile(a_sx_q[DivInW-1:0]);
      b_qb_q    <= div_tile(a_sy_q[DivInW-1:0]);
    end
  end

  always_comb begin
    left_c = b_xneg_q ? '0 : b_ql_q;
    top_c  = b_yneg_q ? '0 : b_qt_q;
    if (b_sxneg_q) begin
      right_c  = '0;
      hempty_c = b_sxfar_q;
    end else begin
      right_c  = (b_qr_q > ColLast) ? ColLast : b_qr_q;
      hempty_c = 1'b0;
    end
    if (b_syneg_q) begin
      bot_c    = '0;
      vempty_c = b_syfar_q;
    end else begin
      bot_c    = (b_qb_q > RowLast) ? RowLast : b_qb_q;
      vempty_c = 1'b0;
    end
    empty_c = hempty_c || vempty_c || (left_c > right_c) || (top_c > bot_c);

    qmask_c = '0;
    wmask_c = '0;
    for (int c = 0; c < MAP_COLS; c++) begin
      qmask_c[c] = (DivInW'(c) >= left_c) && (DivInW'(c) <= right_c);
      wmask_c[c] = (TileColW'(c) == b_col_q);
    end
  end

  assign drop_c = (b_mode_q == MODE_WRITE) &&
                  (({1'b0, b_col_q} >= ColCount) ||
                   ((MaxRowW + 1)'(b_row_q) >= RowCount));

  assign b_adv  = b_valid_q && (drop_c || !full_i);
  assign push_o = b_valid_q && !drop_c && !full_i;

  always_comb begin
    cmd_o.mode   = b_mode_q;
    cmd_o.empty  = empty_c;
    cmd_o.solid  = b_solid_q;
    cmd_o.row_hi = MaxRowW'(bot_c);
    if (b_mode_q == MODE_WRITE) begin
      cmd_o.row_lo = MaxRowW'(b_row_q);
      cmd_o.mask   = wmask_c;
    end else begin
      cmd_o.row_lo = MaxRowW'(top_c);
      cmd_o.mask   = qmask_c;
    end
  end

endmodule

// ===== rtl/tmrc_queue.sv =====
module tmrc_queue import tmrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t                 ent_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW + 1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/tmrc_back.sv =====
module tmrc_back import tmrc_pkg::*; #(
  parameter int unsigned MAP_ROWS = 32,
  parameter int unsigned MAP_COLS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t head_i,
  input  logic empty_i,
  output logic pop_o,
  output logic done_o,
  output logic hit_o
);

  localparam int unsigned RowW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWrite = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [RowW-1:0]     row_q, row_d, last_q, last_d;
  logic [MAP_COLS-1:0] mask_q, mask_d;
  logic                solid_q, solid_d;
  logic [MAP_ROWS-1:0] valid_q, valid_d;
  logic                rvalid_q;
  logic                done_q, done_d, hit_q, hit_d;

  logic                rd_en, wr_en;
  logic [RowW-1:0]     rd_addr;
  logic [MAP_COLS-1:0] rd_data, word, wr_data;
  logic                hit_now;

  tmrc_ram #(
    .Width (MAP_COLS),
    .Depth (MAP_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (row_q),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign word    = rvalid_q ? rd_data : '0;
  assign wr_data = solid_q ? (word | mask_q) : (word & ~mask_q);
  assign hit_now = |(word & mask_q);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    last_d  = last_q;
    mask_d  = mask_q;
    solid_d = solid_q;
    valid_d = valid_q;
    done_d  = 1'b0;
    hit_d   = hit_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = row_q + 1'b1;
    wr_en   = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          row_d   = head_i.row_lo[RowW-1:0];
          last_d  = head_i.row_hi[RowW-1:0];
          mask_d  = head_i.mask[MAP_COLS-1:0];
          solid_d = head_i.solid;
          rd_addr = head_i.row_lo[RowW-1:0];
          priority if (head_i.mode == MODE_WRITE) begin
            rd_en   = 1'b1;
            state_d = StWrite;
          end else if (head_i.empty) begin
            done_d  = 1'b1;
            hit_d   = 1'b0;
          end else begin
            rd_en   = 1'b1;
            state_d = StScan;
          end
        end
      end
      StWrite: begin
        wr_en          = 1'b1;
        valid_d[row_q] = 1'b1;
        state_d        = StIdle;
      end
      StScan: begin
        if (hit_now || (row_q == last_q)) begin
          done_d  = 1'b1;
          hit_d   = hit_now;
          state_d = StIdle;
        end else begin
          rd_en = 1'b1;
          row_d = row_q + 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    last_q   <= last_d;
    mask_q   <= mask_d;
    solid_q  <= solid_d;
    hit_q    <= hit_d;
    rvalid_q <= valid_q[rd_addr];
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

endmodule

// ===== rtl/tile_map_rect_collision.sv =====
// Tile map rectangle collision check.
// Request channel: drive start with one request on the field ports; the request
// is taken at a rising edge where start is high and busy is low. mode_i = 0
// writes one tile (tile_row_i, tile_col_i, tile_id_i, nonzero = solid) and
// gives no result; mode_i = 1 queries the pixel rectangle rect_x_i, rect_y_i,
// rect_w_i, rect_h_i and gives one result.
// Result channel: done_o is high for exactly one cycle with hit_o valid.
// Flow: the front stage divides the edges by TILE_PIXELS in two registered
// steps and hands a command to a two-entry queue. The back end reads a
// query's map rows one row word per cycle from the map RAM, stopping at the
// first row with a solid tile in the span; an empty span returns with no read.
// A write holds the back end for a read and then a write of its row.
// Throughput: the front takes a request every cycle while the queue has room;
// busy rises when the queue is full and both front registers hold a request.
// Sustained rate is set by the row scan: the back end pops only when idle.
// Reset clears the map at once through per-row valid bits and drops all
// requests in flight. The receiver cannot stall; results never wait.
module tile_map_rect_collision import tmrc_pkg::*; #(
  parameter int unsigned TILE_PIXELS = 32,
  parameter int unsigned MAP_ROWS    = 32,
  parameter int unsigned MAP_COLS    = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     mode_i,
  input  logic [TileRowW-1:0]      tile_row_i,
  input  logic [TileColW-1:0]      tile_col_i,
  input  logic [TileIdW-1:0]       tile_id_i,
  input  logic signed [CoordW-1:0] rect_x_i,
  input  logic signed [CoordW-1:0] rect_y_i,
  input  logic [SizeW-1:0]         rect_w_i,
  input  logic [SizeW-1:0]         rect_h_i,
  output logic                     done_o,
  output logic                     hit_o
);

  cmd_t push_cmd, head_cmd;
  logic push, full, pop, empty;

  tmrc_front #(
    .TILE_PIXELS (TILE_PIXELS),
    .MAP_ROWS    (MAP_ROWS),
    .MAP_COLS    (MAP_COLS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_o     (busy),
    .mode_i     (mode_i),
    .tile_row_i (tile_row_i),
    .tile_col_i (tile_col_i),
    .tile_id_i  (tile_id_i),
    .rect_x_i   (rect_x_i),
    .rect_y_i   (rect_y_i),
    .rect_w_i   (rect_w_i),
    .rect_h_i   (rect_h_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tmrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (empty)
  );

  tmrc_back #(
    .MAP_ROWS (MAP_ROWS),
    .MAP_COLS (MAP_COLS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .done_o  (done_o),
    .hit_o   (hit_o)
  );

endmodule

// ===== rtl/tmrc_checker.sv =====
module tmrc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic hit_o
);

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !done_o && !busy)
    else $error("result or busy right after reset");

  a_no_early_result: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !done_o ##1 !done_o ##1 !done_o)
    else $error("result before any request could finish");

  a_idle_stays_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !busy)
    else $error("busy without a request taken");

  a_hit_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(hit_o))
    else $error("unknown hit on result");

endmodule

bind tile_map_rect_collision tmrc_checker u_tmrc_checker (.*);

// ===== tb/sv/tile_map_rect_collision_tb.sv =====
`timescale 1ns / 1ps

module tile_map_rect_collision_tb;
  import tmrc_pkg::*;

  localparam int TilePixels = 32;
  localparam int MapRows    = 32;
  localparam int MapCols    = 64;
  localparam int RandomReqs = 530;
  localparam int DrainCycles = 40;
  localparam int CycleLimit = 200000;

  typedef struct {
    mode_e                     mode;
    logic [TileRowW-1:0]       row;
    logic [TileColW-1:0]       col;
    logic [TileIdW-1:0]        id;
    logic signed [CoordW-1:0]  x;
    logic signed [CoordW-1:0]  y;
    logic [SizeW-1:0]          w;
    logic [SizeW-1:0]          h;
    int unsigned               gap;
  } tile_req_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     mode_i = 1'b0;
  logic [TileRowW-1:0]      tile_row_i = '0;
  logic [TileColW-1:0]      tile_col_i = '0;
  logic [TileIdW-1:0]       tile_id_i = '0;
  logic signed [CoordW-1:0] rect_x_i = '0;
  logic signed [CoordW-1:0] rect_y_i = '0;
  logic [SizeW-1:0]         rect_w_i = '0;
  logic [SizeW-1:0]         rect_h_i = '0;
  logic                     done_o;
  logic                     hit_o;

  tile_req_t   pending_reqs[$];
  tile_req_t   cur_req;
  bit          hit_expected[$];
  bit          hit_want;
  logic [MapCols-1:0] tile_solid [MapRows];
  int unsigned idle_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          fail_count = 0;
  bit          no_gaps = 1'b0;

  tile_map_rect_collision #(
    .TILE_PIXELS(TilePixels),
    .MAP_ROWS   (MapRows),
    .MAP_COLS   (MapCols)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .mode_i    (mode_i),
    .tile_row_i(tile_row_i),
    .tile_col_i(tile_col_i),
    .tile_id_i (tile_id_i),
    .rect_x_i  (rect_x_i),
    .rect_y_i  (rect_y_i),
    .rect_w_i  (rect_w_i),
    .rect_h_i  (rect_h_i),
    .done_o    (done_o),
    .hit_o     (hit_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic tile_req_t noise_req();
    tile_req_t req;
    req.mode = MODE_WRITE;
    req.row  = TileRowW'($urandom);
    req.col  = TileColW'($urandom);
    req.id   = TileIdW'($urandom);
    req.x    = CoordW'($urandom);
    req.y    = CoordW'($urandom);
    req.w    = SizeW'($urandom);
    req.h    = SizeW'($urandom);
    req.gap  = no_gaps ? 0 : $urandom_range(0, 3);
    return req;
  endfunction

  function automatic void add_write(int row, int col, int id);
    tile_req_t req;
    req      = noise_req();
    req.mode = MODE_WRITE;
    req.row  = TileRowW'(row);
    req.col  = TileColW'(col);
    req.id   = TileIdW'(id);
    pending_reqs.push_back(req);
  endfunction

  function automatic void add_query(int x, int y, int w, int h);
    tile_req_t req;
    req      = noise_req();
    req.mode = MODE_QUERY;
    req.x    = CoordW'(x);
    req.y    = CoordW'(y);
    req.w    = SizeW'(w);
    req.h    = SizeW'(h);
    pending_reqs.push_back(req);
  endfunction

  function automatic void predict_request(tile_req_t req);
    int left, right, top, bottom;
    bit found;
    found = 1'b0;
    if (req.mode == MODE_WRITE) begin
      tile_solid[req.row][req.col] = (req.id != '0);
    end else begin
      left   = int'(req.x) / TilePixels;
      right  = (int'(req.x) + int'(req.w)) / TilePixels;
      top    = int'(req.y) / TilePixels;
      bottom = (int'(req.y) + int'(req.h)) / TilePixels;
      if (left < 0) left = 0;
      if (top < 0) top = 0;
      if (right > MapCols - 1) right = MapCols - 1;
      if (bottom > MapRows - 1) bottom = MapRows - 1;
      if (left <= right && top <= bottom) begin
        for (int r = top; r <= bottom; r++) begin
          for (int c = left; c <= right; c++) begin
            found |= tile_solid[r][c];
          end
        end
      end
      hit_expected.push_back(found);
    end
  endfunction

  // Driver: hold each request until taken, then wait the next request's drawn gap.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_request(cur_req);
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && idle_cnt >= pending_reqs[0].gap) begin
          cur_req = pending_reqs.pop_front();
          start      <= 1'b1;
          mode_i     <= cur_req.mode;
          tile_row_i <= cur_req.row;
          tile_col_i <= cur_req.col;
          tile_id_i  <= cur_req.id;
          rect_x_i   <= cur_req.x;
          rect_y_i   <= cur_req.y;
          rect_w_i   <= cur_req.w;
          rect_h_i   <= cur_req.h;
          idle_cnt   <= 0;
        end else begin
          start <= 1'b0;
          if (pending_reqs.size() != 0) idle_cnt <= idle_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (hit_expected.size() == 0) begin
        $error("hit_o: unexpected result, actual %0b", hit_o);
        fail_count++;
      end else begin
        hit_want = hit_expected.pop_front();
        if (hit_o !== hit_want) begin
          $error("hit_o: expected %0b, actual %0b", hit_want, hit_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tile_map_rect_collision_tb: FAIL");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < MapRows; r++) tile_solid[r] = '0;

    add_query(-4096, -4096, 4095, 4095);
    add_write(0, 0, 16'hFFFF);
    add_write(31, 63, 16'h0001);
    add_query(0, 0, 0, 0);
    add_query(-31, -31, 0, 0);
    add_query(-33, 0, 0, 0);
    add_query(2016, 992, 0, 0);
    add_query(4095, 4095, 4095, 4095);
    add_query(-4096, 0, 4095, 0);
    add_query(0, 2000, 100, 4095);
    add_write(5, 10, 16'h8000);
    add_query(288, 160, 32, 0);
    add_query(288, 160, 31, 0);
    add_query(320, 128, 0, 32);
    add_query(320, 128, 0, 31);
    add_write(5, 10, 16'h0000);
    add_query(320, 160, 0, 0);
    add_write(31, 63, 16'h0000);
    add_query(-4096, -4096, 4095, 4095);
    add_write(0, 0, 16'h0000);
    add_query(-4096, -4096, 4095, 4095);
    add_query(1000, 500, 4095, 4095);
    add_write(20, 40, 16'h0002);
    add_query(1000, 500, 4095, 4095);

    for (int i = 0; i < RandomReqs; i++) begin
      no_gaps = ((i / 40) % 3) == 1;
      if ($urandom_range(0, 99) < 40) begin
        add_write($urandom_range(0, 31), $urandom_range(0, 63),
                  ($urandom_range(0, 99) < 65) ? $urandom_range(1, 65535) : 0);
      end else if ($urandom_range(0, 99) < 20) begin
        add_query($urandom_range(0, 8191) - 4096, $urandom_range(0, 8191) - 4096,
                  $urandom_range(0, 4095), $urandom_range(0, 4095));
      end else begin
        add_query($urandom_range(0, 2164) - 64, $urandom_range(0, 1164) - 64,
                  $urandom_range(0, 160), $urandom_range(0, 160));
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || start) @(posedge clk_i);
    while (hit_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tile_map_rect_collision_tb: PASS");
    end else begin
      $display("tile_map_rect_collision_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== tile_map_rect_collision.f =====
rtl/tmrc_pkg.sv
rtl/tmrc_ram.sv
rtl/tmrc_front.sv
rtl/tmrc_queue.sv
rtl/tmrc_back.sv
rtl/tile_map_rect_collision.sv
rtl/tmrc_checker.sv
tb/sv/tile_map_rect_collision_tb.sv
